@@ sv/nacs_pkg.sv @@
package nacs_pkg;

  localparam int unsigned ADDR_W = 40;

  // request codes
  localparam logic [3:0] OP_READ_BEGIN     = 4'd0;
  localparam logic [3:0] OP_READ_ADDRESS   = 4'd1;
  localparam logic [3:0] OP_PAGE_DONE      = 4'd2;
  localparam logic [3:0] OP_PROGRAM        = 4'd3;
  localparam logic [3:0] OP_PROGRAM_CONFIRM = 4'd4;
  localparam logic [3:0] OP_ERASE          = 4'd5;
  localparam logic [3:0] OP_STATUS         = 4'd6;
  localparam logic [3:0] OP_RESET          = 4'd7;
  localparam logic [3:0] OP_READ_ID        = 4'd8;

  // result kinds
  localparam logic [1:0] KIND_CMD     = 2'd0;
  localparam logic [1:0] KIND_ADDR    = 2'd1;
  localparam logic [1:0] KIND_VERDICT = 2'd2;

  // status verdicts
  localparam logic [1:0] VERDICT_OK        = 2'd0;
  localparam logic [1:0] VERDICT_NOT_READY = 2'd1;
  localparam logic [1:0] VERDICT_FAILED    = 2'd2;

  // NAND command bytes
  localparam logic [7:0] CMD_RESET         = 8'hFF;
  localparam logic [7:0] CMD_READ_ID       = 8'h90;
  localparam logic [7:0] CMD_READ_STATUS   = 8'h70;
  localparam logic [7:0] CMD_READ_SETUP    = 8'h00;
  localparam logic [7:0] CMD_READ_START    = 8'h30;
  localparam logic [7:0] CMD_PROGRAM       = 8'h80;
  localparam logic [7:0] CMD_PROGRAM_CONF  = 8'h10;
  localparam logic [7:0] CMD_ERASE         = 8'h60;
  localparam logic [7:0] CMD_ERASE_CONF    = 8'hD0;

  // register indexes
  localparam logic [2:0] REG_COLUMN_TOP_BIT = 3'd0;
  localparam logic [2:0] REG_ROW_SHIFT      = 3'd1;
  localparam logic [2:0] REG_COLUMN_BYTES   = 3'd2;
  localparam logic [2:0] REG_ROW_BYTES      = 3'd3;
  localparam logic [2:0] REG_KEEP_ADDRESS   = 3'd4;

  // register reset values
  localparam logic [3:0] RST_COLUMN_TOP_BIT = 4'd11;
  localparam logic [4:0] RST_ROW_SHIFT      = 5'd12;
  localparam logic [1:0] RST_COLUMN_BYTES   = 2'd2;
  localparam logic [1:0] RST_ROW_BYTES      = 2'd3;
  localparam logic       RST_KEEP_ADDRESS   = 1'b0;

  typedef struct packed {
    logic [3:0] column_top_bit;
    logic [4:0] row_shift;
    logic [1:0] column_bytes;
    logic [1:0] row_bytes;
    logic       keep_address;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] bus_byte;
    logic [1:0] verdict;
  } ent_t;

  // one request's run: head entry, address bytes (LSB first), optional tail
  typedef struct packed {
    ent_t              head;
    logic [2:0]        addr_cnt;
    logic [ADDR_W-1:0] addr_word;
    logic              has_tail;
    ent_t              tail;
  } desc_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEAD,
    PH_ADDR,
    PH_TAIL
  } phase_t;

  function automatic ent_t mk_ent(input logic [1:0] kind, input logic [7:0] bus_byte,
                                  input logic [1:0] verdict);
    ent_t e;
    e.kind     = kind;
    e.bus_byte = bus_byte;
    e.verdict  = verdict;
    return e;
  endfunction

endpackage

@@ sv/nacs_front.sv @@
module nacs_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  nacs_pkg::cfg_t          cfg,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [3:0]              in_opcode,
  input  logic [39:0]             in_byte_address,
  input  logic [7:0]              in_status_byte,
  input  logic                    in_device_ready,
  input  logic                    q_full,
  output logic                    q_push,
  output nacs_pkg::desc_t         q_desc
);

  logic        accept;
  logic        loaded_r;
  logic        loaded_nxt;
  logic        loaded_new;
  logic        has_run;
  logic [4:0]  col_lsb;
  logic [4:0]  half_w;
  logic [1:0]  col_cnt;
  logic [2:0]  full_cnt;
  logic [39:0] col_mask;
  logic [39:0] row_part;
  logic [39:0] addr_word;
  logic [39:0] off_src;
  logic [7:0]  off_mask;
  logic [7:0]  half_off;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // address assembly
  assign col_lsb   = {1'b0, cfg.column_top_bit} + 5'd1;
  assign col_cnt   = (cfg.column_bytes == 2'd3) ? 2'd2 : cfg.column_bytes;
  assign full_cnt  = {1'b0, col_cnt} + {1'b0, cfg.row_bytes};
  assign col_mask  = ~({40{1'b1}} << col_lsb);
  assign row_part  = in_byte_address >> cfg.row_shift;
  assign addr_word = (in_byte_address & col_mask) | (row_part << {col_cnt, 3'b000});

  // half-page offset sits between the column and row fields
  assign half_w   = cfg.row_shift - col_lsb;
  assign off_src  = in_byte_address >> col_lsb;
  assign off_mask = (half_w >= 5'd8) ? 8'hFF : ~(8'hFF << half_w);
  assign half_off = (cfg.row_shift > col_lsb) ? (off_src[7:0] & off_mask) : 8'h00;

  always_comb begin
    has_run    = 1'b0;
    loaded_new = loaded_r;
    q_desc     = '0;
    case (in_opcode)
      nacs_pkg::OP_READ_BEGIN: begin
        loaded_new = 1'b0;
      end
      nacs_pkg::OP_READ_ADDRESS: begin
        if (!loaded_r) begin
          has_run          = 1'b1;
          q_desc.head      = nacs_pkg::mk_ent(nacs_pkg::KIND_CMD,
                               nacs_pkg::CMD_READ_SETUP | half_off, nacs_pkg::VERDICT_OK);
          q_desc.addr_cnt  = full_cnt;
          q_desc.addr_word = addr_word;
          q_desc.has_tail  = 1'b1;
          q_desc.tail      = nacs_pkg::mk_ent(nacs_pkg::KIND_CMD,
                               nacs_pkg::CMD_READ_START, nacs_pkg::VERDICT_OK);
          loaded_new       = 1'b1;
        end
      end
      nacs_pkg::OP_PAGE_DONE: begin
        if (!cfg.keep_address) begin
          loaded_new = 1'b0;
        end
      end
      nacs_pkg::OP_PROGRAM: begin
        has_run          = 1'b1;
        q_desc.head      = nacs_pkg::mk_ent(nacs_pkg::KIND_CMD,
                             nacs_pkg::CMD_PROGRAM, nacs_pkg::VERDICT_OK);
        q_desc.addr_cnt  = full_cnt;
        q_desc.addr_word = addr_word;
      end
      nacs_pkg::OP_PROGRAM_CONFIRM: begin
        has_run     = 1'b1;
        q_desc.head = nacs_pkg::mk_ent(nacs_pkg::KIND_CMD,
                        nacs_pkg::CMD_PROGRAM_CONF, nacs_pkg::VERDICT_OK);
      end
      nacs_pkg::OP_ERASE: begin
        has_run          = 1'b1;
        q_desc.head      = nacs_pkg::mk_ent(nacs_pkg::KIND_CMD,
                             nacs_pkg::CMD_ERASE, nacs_pkg::VERDICT_OK);
        q_desc.addr_cnt  = {1'b0, cfg.row_bytes};
        q_desc.addr_word = row_part;
        q_desc.has_tail  = 1'b1;
        q_desc.tail      = nacs_pkg::mk_ent(nacs_pkg::KIND_CMD,
                             nacs_pkg::CMD_ERASE_CONF, nacs_pkg::VERDICT_OK);
      end
      nacs_pkg::OP_STATUS: begin
        has_run = 1'b1;
        if (in_device_ready) begin
          q_desc.head     = nacs_pkg::mk_ent(nacs_pkg::KIND_CMD,
                              nacs_pkg::CMD_READ_STATUS, nacs_pkg::VERDICT_OK);
          q_desc.has_tail = 1'b1;
          q_desc.tail     = nacs_pkg::mk_ent(nacs_pkg::KIND_VERDICT, 8'h00,
                              in_status_byte[0] ? nacs_pkg::VERDICT_FAILED
                                                : nacs_pkg::VERDICT_OK);
        end else begin
          q_desc.head = nacs_pkg::mk_ent(nacs_pkg::KIND_VERDICT, 8'h00,
                          nacs_pkg::VERDICT_NOT_READY);
        end
      end
      nacs_pkg::OP_RESET: begin
        has_run     = 1'b1;
        q_desc.head = nacs_pkg::mk_ent(nacs_pkg::KIND_CMD,
                        nacs_pkg::CMD_RESET, nacs_pkg::VERDICT_OK);
      end
      nacs_pkg::OP_READ_ID: begin
        has_run         = 1'b1;
        q_desc.head     = nacs_pkg::mk_ent(nacs_pkg::KIND_CMD,
                            nacs_pkg::CMD_READ_ID, nacs_pkg::VERDICT_OK);
        q_desc.addr_cnt = 3'd1;
      end
      default: begin
      end
    endcase
  end

  assign q_push     = accept && has_run;
  assign loaded_nxt = accept ? loaded_new : loaded_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
    end else begin
      loaded_r <= loaded_nxt;
    end
  end

endmodule

@@ sv/nacs_queue.sv @@
module nacs_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  nacs_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output nacs_pkg::desc_t pop_data,
  output logic            empty
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  nacs_pkg::desc_t entries [DEPTH];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r;
  logic [PtrW-1:0] rd_ptr_nxt;
  logic [CntW-1:0] count_r;
  logic [CntW-1:0] count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full     = (count_r == CntW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ sv/nacs_back.sv @@
module nacs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  nacs_pkg::desc_t q_data,
  output logic            q_pop,
  output logic            out_empty,
  input  logic            out_pop,
  output logic [1:0]      out_cycle_kind,
  output logic [7:0]      out_bus_byte,
  output logic [1:0]      out_verdict,
  output logic            out_last
);

  nacs_pkg::phase_t phase_r;
  nacs_pkg::phase_t phase_nxt;
  nacs_pkg::desc_t  cur_r;
  nacs_pkg::desc_t  cur_nxt;
  nacs_pkg::ent_t   emit;
  nacs_pkg::ent_t   out_ent_r;
  nacs_pkg::ent_t   out_ent_nxt;
  logic             emit_last;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             out_last_r;
  logic             out_last_nxt;
  logic             out_load;
  logic             fire;

  // output register takes a new item when empty or being drained
  assign out_load = !out_valid_r || out_pop;
  assign fire     = out_load && (phase_r != nacs_pkg::PH_IDLE);

  always_comb begin
    emit      = '0;
    emit_last = 1'b0;
    case (phase_r)
      nacs_pkg::PH_HEAD: begin
        emit      = cur_r.head;
        emit_last = (cur_r.addr_cnt == 3'd0) && !cur_r.has_tail;
      end
      nacs_pkg::PH_ADDR: begin
        emit      = nacs_pkg::mk_ent(nacs_pkg::KIND_ADDR, cur_r.addr_word[7:0],
                                     nacs_pkg::VERDICT_OK);
        emit_last = (cur_r.addr_cnt == 3'd1) && !cur_r.has_tail;
      end
      nacs_pkg::PH_TAIL: begin
        emit      = cur_r.tail;
        emit_last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    q_pop     = 1'b0;
    if (fire) begin
      case (phase_r)
        nacs_pkg::PH_HEAD: begin
          phase_nxt = (cur_r.addr_cnt != 3'd0) ? nacs_pkg::PH_ADDR : nacs_pkg::PH_TAIL;
        end
        nacs_pkg::PH_ADDR: begin
          cur_nxt.addr_word = cur_r.addr_word >> 8;
          cur_nxt.addr_cnt  = cur_r.addr_cnt - 3'd1;
          phase_nxt = (cur_r.addr_cnt == 3'd1) ? nacs_pkg::PH_TAIL : nacs_pkg::PH_ADDR;
        end
        default: begin
        end
      endcase
    end
    // fetch the next run in the cycle the current one ends, so runs abut
    if ((phase_r == nacs_pkg::PH_IDLE) || (fire && emit_last)) begin
      if (!q_empty) begin
        q_pop     = 1'b1;
        cur_nxt   = q_data;
        phase_nxt = nacs_pkg::PH_HEAD;
      end else begin
        phase_nxt = nacs_pkg::PH_IDLE;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ent_nxt   = out_ent_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = fire;
      out_ent_nxt   = emit;
      out_last_nxt  = emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= nacs_pkg::PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_ent_r  <= out_ent_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_cycle_kind = out_ent_r.kind;
  assign out_bus_byte   = out_ent_r.bus_byte;
  assign out_verdict    = out_ent_r.verdict;
  assign out_last       = out_last_r;

endmodule

@@ sv/nand_command_address_sequencer.sv @@
// NAND command/address sequencer. Each request pushed on the input queue is
// decoded in its accept cycle into a run descriptor (head command or status
// verdict, up to five address bytes, optional tail command or status verdict)
// and parked in a QUEUE_DEPTH-entry descriptor queue; the back end plays runs
// out one result per cycle into a single registered output slot, stalling while
// that slot is full and not popped. A request yields 1 to 7 results; runs abut
// with no gap. Requests with no results (read begin, page done, a read address
// while one is loaded, unused codes) never reach the queue. The input side
// keeps accepting until the descriptor queue is full. Configuration is read
// when a request is accepted, so it must be written while the block is idle.
module nand_command_address_sequencer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [3:0]  in_opcode,
  input  logic [39:0] in_byte_address,
  input  logic [7:0]  in_status_byte,
  input  logic        in_device_ready,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_cycle_kind,
  output logic [7:0]  out_bus_byte,
  output logic [1:0]  out_verdict,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  nacs_pkg::cfg_t  cfg_r;
  nacs_pkg::cfg_t  cfg_nxt;
  nacs_pkg::desc_t push_desc;
  nacs_pkg::desc_t pop_desc;
  logic [2:0]      reg_idx;
  logic            reg_wr;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign reg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      case (reg_idx)
        nacs_pkg::REG_COLUMN_TOP_BIT: cfg_nxt.column_top_bit = pwdata[3:0];
        nacs_pkg::REG_ROW_SHIFT:      cfg_nxt.row_shift      = pwdata[4:0];
        nacs_pkg::REG_COLUMN_BYTES:   cfg_nxt.column_bytes   = pwdata[1:0];
        nacs_pkg::REG_ROW_BYTES:      cfg_nxt.row_bytes      = pwdata[1:0];
        nacs_pkg::REG_KEEP_ADDRESS:   cfg_nxt.keep_address   = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      nacs_pkg::REG_COLUMN_TOP_BIT: prdata = {28'd0, cfg_r.column_top_bit};
      nacs_pkg::REG_ROW_SHIFT:      prdata = {27'd0, cfg_r.row_shift};
      nacs_pkg::REG_COLUMN_BYTES:   prdata = {30'd0, cfg_r.column_bytes};
      nacs_pkg::REG_ROW_BYTES:      prdata = {30'd0, cfg_r.row_bytes};
      nacs_pkg::REG_KEEP_ADDRESS:   prdata = {31'd0, cfg_r.keep_address};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.column_top_bit <= nacs_pkg::RST_COLUMN_TOP_BIT;
      cfg_r.row_shift      <= nacs_pkg::RST_ROW_SHIFT;
      cfg_r.column_bytes   <= nacs_pkg::RST_COLUMN_BYTES;
      cfg_r.row_bytes      <= nacs_pkg::RST_ROW_BYTES;
      cfg_r.keep_address   <= nacs_pkg::RST_KEEP_ADDRESS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  nacs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_opcode       (in_opcode),
    .in_byte_address (in_byte_address),
    .in_status_byte  (in_status_byte),
    .in_device_ready (in_device_ready),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_desc          (push_desc)
  );

  nacs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_desc),
    .empty     (q_empty)
  );

  nacs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_data         (pop_desc),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_cycle_kind (out_cycle_kind),
    .out_bus_byte   (out_bus_byte),
    .out_verdict    (out_verdict),
    .out_last       (out_last)
  );

  a_reset_drains: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  a_verdict_only_in_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_cycle_kind != nacs_pkg::KIND_VERDICT) |-> out_verdict == 2'd0)
    else $error("verdict set on a bus cycle");

  a_verdict_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_cycle_kind == nacs_pkg::KIND_VERDICT) |-> out_last)
    else $error("status verdict not marked last");

  a_verdict_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_cycle_kind == nacs_pkg::KIND_VERDICT) |-> out_bus_byte == 8'h00)
    else $error("status verdict carries a bus byte");

endmodule
